[hdl/spjq_pkg.sv]
// ---------------------------------------------------------------------------
// spjq_pkg
// Types and codes shared by the stable priority job queue.
// ---------------------------------------------------------------------------
`default_nettype none

package spjq_pkg;

  localparam logic OP_PUSH = 1'b0;
  localparam logic OP_POP  = 1'b1;

  typedef enum logic [1:0] {
    ST_PUSHED = 2'd0,
    ST_FULL   = 2'd1,
    ST_POPPED = 2'd2,
    ST_EMPTY  = 2'd3
  } status_e;

  typedef enum logic [2:0] {
    FSM_IDLE,
    FSM_PUSH,
    FSM_SCAN,
    FSM_DRAIN,
    FSM_DONE
  } fsm_e;

  typedef struct packed {
    logic        operation;
    logic [31:0] job_handle;
    logic [31:0] job_data;
    logic [15:0] job_length;
    logic [7:0]  job_priority;
  } spjq_in_t;

  typedef struct packed {
    status_e     status;
    logic [31:0] out_handle;
    logic [31:0] out_data;
    logic [15:0] out_length;
    logic [7:0]  out_priority;
  } spjq_out_t;

  // job as held in the slot memory (the age stamp sits beside it)
  typedef struct packed {
    logic [31:0] handle;
    logic [31:0] data;
    logic [15:0] length;
    logic [7:0]  prio;
  } job_t;

  localparam int JOB_W = $bits(job_t);

  // controls from the sequencer to the selector
  typedef struct packed {
    logic start;   // forget the previous best
    logic sample;  // read data of one slot is present
  } sel_ctrl_t;

endpackage

`default_nettype wire

[hdl/spjq_ram.sv]
// ---------------------------------------------------------------------------
// spjq_ram
// Generic simple dual-port RAM: one write port, one read port, registered read.
// ---------------------------------------------------------------------------
`default_nettype none

module spjq_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(DEPTH)-1:0] waddr_i,
  input  wire logic [WIDTH-1:0]         wdata_i,
  input  wire logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic      [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

`default_nettype wire

[hdl/spjq_sel.sv]
// ---------------------------------------------------------------------------
// spjq_sel
// Best-job selector: takes one slot per cycle from the scan, applies the
// pending age correction of the previous pop and keeps the running best.
// ---------------------------------------------------------------------------
`default_nettype none

module spjq_sel #(
  parameter int IDX_W   = 4,
  parameter int STAMP_W = 4
) (
  input  wire logic                   clk_i,
  input  wire logic                   rst_ni,
  input  wire spjq_pkg::sel_ctrl_t    ctrl_i,
  input  wire logic [IDX_W-1:0]       rd_idx_i,
  input  wire spjq_pkg::job_t         rd_job_i,
  input  wire logic [STAMP_W-1:0]     rd_stamp_i,
  input  wire logic                   slot_valid_i,
  input  wire logic                   slot_fix_i,
  input  wire logic [STAMP_W-1:0]     gone_i,
  output logic                        wb_en_o,
  output logic      [STAMP_W-1:0]     wb_stamp_o,
  output logic                        found_o,
  output logic      [IDX_W-1:0]       best_idx_o,
  output logic      [STAMP_W-1:0]     best_stamp_o,
  output spjq_pkg::job_t              best_job_o
);

  logic               found_q;
  logic [IDX_W-1:0]   idx_q;
  logic [STAMP_W-1:0] stamp_q;
  spjq_pkg::job_t     job_q;

  logic [STAMP_W-1:0] stamp_fixed;
  logic               better;

  always_comb begin
    // jobs younger than the last popped one move up one rank
    if (slot_fix_i && (rd_stamp_i > gone_i)) begin
      stamp_fixed = rd_stamp_i - STAMP_W'(1);
    end else begin
      stamp_fixed = rd_stamp_i;
    end
    better = slot_valid_i &&
             (!found_q ||
              (rd_job_i.prio > job_q.prio) ||
              ((rd_job_i.prio == job_q.prio) && (stamp_fixed < stamp_q)));
    wb_en_o    = ctrl_i.sample && slot_valid_i && slot_fix_i;
    wb_stamp_o = stamp_fixed;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      found_q <= 1'b0;
    end else if (ctrl_i.start) begin
      found_q <= 1'b0;
    end else if (ctrl_i.sample && better) begin
      found_q <= 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctrl_i.sample && better) begin
      idx_q   <= rd_idx_i;
      stamp_q <= stamp_fixed;
      job_q   <= rd_job_i;
    end
  end

  assign found_o      = found_q;
  assign best_idx_o   = idx_q;
  assign best_stamp_o = stamp_q;
  assign best_job_o   = job_q;

endmodule

`default_nettype wire

[hdl/stable_priority_job_queue.sv]
// ---------------------------------------------------------------------------
// stable_priority_job_queue
// Table of pending jobs; push into the lowest free slot, pop the highest
// priority job, oldest first among equals.
// ---------------------------------------------------------------------------
//  channel | direction | handshake                 | payload
//  in      | input     | in_valid_i / in_stall_o   | in_item_i  (spjq_in_t)
//  out     | output    | out_valid_o / out_stall_i | out_item_o (spjq_out_t)
//
//  Push: the accepted item waits in the PUSH state until the output is free;
//  the slot write and the result register happen in the same cycle.
//  Pop: the SCAN state reads the slot RAM through its single read port, one
//  slot per cycle; the registered read data goes to the selector, then the
//  DRAIN and DONE states follow and DONE registers the result once the output
//  is free.
//  One item at a time; the next is taken once the result is registered, while
//  that result may still be stalled at the output.
//  Reset clears the valid bits, counters and handshake state; the slot RAM is
//  not cleared, as only the contents of valid slots are ever used.
// ---------------------------------------------------------------------------
`default_nettype none

module stable_priority_job_queue #(
  parameter int QUEUE_DEPTH = 16
) (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               in_valid_i,
  output logic                    in_stall_o,
  input  wire spjq_pkg::spjq_in_t in_item_i,
  output logic                    out_valid_o,
  input  wire logic               out_stall_i,
  output spjq_pkg::spjq_out_t     out_item_o
);

  localparam int IDX_W   = $clog2(QUEUE_DEPTH);
  localparam int STAMP_W = $clog2(QUEUE_DEPTH);
  localparam int CNT_W   = $clog2(QUEUE_DEPTH + 1);
  localparam int WORD_W  = STAMP_W + spjq_pkg::JOB_W;
  localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(QUEUE_DEPTH - 1);

  spjq_pkg::fsm_e       state_q, state_d;
  spjq_pkg::spjq_in_t   req_q;
  logic [QUEUE_DEPTH-1:0] valid_q, valid_d;
  logic [QUEUE_DEPTH-1:0] fix_q, fix_d;
  logic [CNT_W-1:0]     count_q, count_d;
  logic [STAMP_W-1:0]   gone_q, gone_d;
  logic [IDX_W-1:0]     scan_q, scan_d;
  logic [IDX_W-1:0]     rd_idx_q;
  logic                 sample_q;
  logic                 out_valid_q, out_valid_d;
  spjq_pkg::spjq_out_t  out_item_q, out_item_d;

  logic                 accept;
  logic                 out_free;
  logic                 full;
  logic [IDX_W-1:0]     free_idx;

  logic                 ram_we;
  logic [IDX_W-1:0]     ram_waddr;
  logic [WORD_W-1:0]    ram_wdata;
  logic [WORD_W-1:0]    ram_rdata;
  spjq_pkg::job_t       new_job;

  spjq_pkg::sel_ctrl_t  sel_ctrl;
  logic                 wb_en;
  logic [STAMP_W-1:0]   wb_stamp;
  logic                 best_found;
  logic [IDX_W-1:0]     best_idx;
  logic [STAMP_W-1:0]   best_stamp;
  spjq_pkg::job_t       best_job;

  spjq_ram #(
    .WIDTH (WORD_W),
    .DEPTH (QUEUE_DEPTH)
  ) u_slot_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .raddr_i (scan_q),
    .rdata_o (ram_rdata)
  );

  spjq_sel #(
    .IDX_W   (IDX_W),
    .STAMP_W (STAMP_W)
  ) u_sel (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .ctrl_i       (sel_ctrl),
    .rd_idx_i     (rd_idx_q),
    .rd_job_i     (ram_rdata[spjq_pkg::JOB_W-1:0]),
    .rd_stamp_i   (ram_rdata[WORD_W-1:spjq_pkg::JOB_W]),
    .slot_valid_i (valid_q[rd_idx_q]),
    .slot_fix_i   (fix_q[rd_idx_q]),
    .gone_i       (gone_q),
    .wb_en_o      (wb_en),
    .wb_stamp_o   (wb_stamp),
    .found_o      (best_found),
    .best_idx_o   (best_idx),
    .best_stamp_o (best_stamp),
    .best_job_o   (best_job)
  );

  // lowest-numbered free slot
  always_comb begin
    free_idx = '0;
    for (int k = QUEUE_DEPTH - 1; k >= 0; k--) begin
      if (!valid_q[k]) begin
        free_idx = IDX_W'(k);
      end
    end
  end

  assign full     = &valid_q;
  assign accept   = in_valid_i && (state_q == spjq_pkg::FSM_IDLE);
  assign out_free = !out_valid_q || !out_stall_i;

  always_comb begin
    new_job.handle = req_q.job_handle;
    new_job.data   = req_q.job_data;
    new_job.length = req_q.job_length;
    new_job.prio   = req_q.job_priority;
  end

  always_comb begin
    state_d     = state_q;
    valid_d     = valid_q;
    fix_d       = fix_q;
    count_d     = count_q;
    gone_d      = gone_q;
    scan_d      = scan_q;
    out_valid_d = out_valid_q;
    out_item_d  = out_item_q;
    sel_ctrl    = '0;
    sel_ctrl.sample = sample_q;
    in_stall_o  = (state_q != spjq_pkg::FSM_IDLE);

    if (out_valid_q && !out_stall_i) begin
      out_valid_d = 1'b0;
    end

    // age correction write-back during the scan
    ram_we    = wb_en;
    ram_waddr = rd_idx_q;
    ram_wdata = {wb_stamp, ram_rdata[spjq_pkg::JOB_W-1:0]};
    if (wb_en) begin
      fix_d[rd_idx_q] = 1'b0;
    end

    case (state_q)
      spjq_pkg::FSM_IDLE: begin
        if (in_valid_i) begin
          if (in_item_i.operation == spjq_pkg::OP_POP) begin
            sel_ctrl.start = 1'b1;
            scan_d         = '0;
            state_d        = spjq_pkg::FSM_SCAN;
          end else begin
            state_d = spjq_pkg::FSM_PUSH;
          end
        end
      end
      spjq_pkg::FSM_PUSH: begin
        if (out_free) begin
          out_valid_d = 1'b1;
          out_item_d  = '0;
          state_d     = spjq_pkg::FSM_IDLE;
          if (full) begin
            out_item_d.status = spjq_pkg::ST_FULL;
          end else begin
            out_item_d.status = spjq_pkg::ST_PUSHED;
            ram_we            = 1'b1;
            ram_waddr         = free_idx;
            ram_wdata         = {count_q[STAMP_W-1:0], new_job};
            valid_d[free_idx] = 1'b1;
            fix_d[free_idx]   = 1'b0;
            count_d           = count_q + CNT_W'(1);
          end
        end
      end
      spjq_pkg::FSM_SCAN: begin
        scan_d = scan_q + IDX_W'(1);
        if (scan_q == LAST_IDX) begin
          scan_d  = scan_q;
          state_d = spjq_pkg::FSM_DRAIN;
        end
      end
      spjq_pkg::FSM_DRAIN: begin
        state_d = spjq_pkg::FSM_DONE;
      end
      spjq_pkg::FSM_DONE: begin
        if (out_free) begin
          out_valid_d = 1'b1;
          out_item_d  = '0;
          state_d     = spjq_pkg::FSM_IDLE;
          if (best_found) begin
            out_item_d.status       = spjq_pkg::ST_POPPED;
            out_item_d.out_handle   = best_job.handle;
            out_item_d.out_data     = best_job.data;
            out_item_d.out_length   = best_job.length;
            out_item_d.out_priority = best_job.prio;
            valid_d[best_idx]       = 1'b0;
            // survivors get their ranks fixed on the next scan
            fix_d                   = valid_q;
            fix_d[best_idx]         = 1'b0;
            gone_d                  = best_stamp;
            count_d                 = count_q - CNT_W'(1);
          end else begin
            out_item_d.status = spjq_pkg::ST_EMPTY;
          end
        end
      end
      default: begin
        state_d = spjq_pkg::FSM_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= spjq_pkg::FSM_IDLE;
      valid_q     <= '0;
      fix_q       <= '0;
      count_q     <= '0;
      gone_q      <= '0;
      scan_q      <= '0;
      sample_q    <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      valid_q     <= valid_d;
      fix_q       <= fix_d;
      count_q     <= count_d;
      gone_q      <= gone_d;
      scan_q      <= scan_d;
      sample_q    <= (state_q == spjq_pkg::FSM_SCAN);
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      req_q <= in_item_i;
    end
    rd_idx_q   <= scan_q;
    out_item_q <= out_item_d;
  end

  assign out_valid_o = out_valid_q;
  assign out_item_o  = out_item_q;

  // fill count tracks the valid bits
  a_count_matches: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q == CNT_W'($countones(valid_q)))
    else $error("job count out of step with valid bits");

  // pending rank fixes only for pending jobs
  a_fix_in_valid: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (fix_q & ~valid_q) == '0)
    else $error("rank fix pending on an empty slot");

  // the popped slot is freed
  a_pop_frees: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == spjq_pkg::FSM_DONE && out_free && best_found)
      |=> !valid_q[$past(best_idx)])
    else $error("popped slot still valid");

  // only a pop carries a job
  a_zero_fields: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && out_item_q.status != spjq_pkg::ST_POPPED)
      |-> (out_item_q.out_handle == '0 && out_item_q.out_data == '0 &&
           out_item_q.out_length == '0 && out_item_q.out_priority == '0))
    else $error("non-pop result carries job fields");

endmodule

`default_nettype wire
